@@ rtl/core/nvp_pkg.sv @@
// Shared types and constants for the name-value pair stream decoder.
package nvp_pkg;

   // Parser phase within the pair stream.
   typedef enum logic [2:0] {
      PH_NAME_LEN       = 3'd0,
      PH_NAME_LEN_MORE  = 3'd1,
      PH_VALUE_LEN      = 3'd2,
      PH_VALUE_LEN_MORE = 3'd3,
      PH_DATA           = 3'd4,
      PH_CLOSED         = 3'd5
   } phase_type;

   // Status codes reported with each result word.
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_COMPLETE    = 3'd1,
      ST_MISSING_VAL = 3'd2,
      ST_TRUNC_LEN   = 3'd3,
      ST_TRUNC_DATA  = 3'd4
   } status_type;

   // Label of each result word.
   typedef enum logic [1:0] {
      KIND_LENGTH = 2'd0,
      KIND_NAME   = 2'd1,
      KIND_VALUE  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   // Input command codes.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Field widths.
   localparam int LEN_W   = 31;
   localparam int LEFT_W  = 32;
   localparam int COUNT_W = 16;
   localparam int BYTE_W  = 8;

   // Result word data bus: byte, name length, value length, pair count, status.
   localparam int RSP_FIELDS_W = BYTE_W + 2 * LEN_W + COUNT_W + 3;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Saturation limit of the pair counter.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

@@ rtl/core/name_value_pair_stream_decoder.sv @@
// Name-value pair stream decoder: top level with input register and result register.
//
// The block parses a byte stream of name-value pairs at one word per clock when not stalled. Each pair is a
// name length, a value length (each one byte, or four big-endian bytes when bit 7 of the
// first is set), then name bytes and value bytes. Every input word yields exactly one result
// word labeled as a length, name, value or end-marker word; rsp_tlast marks the word that
// completes a pair and the running lengths and pair count travel with it. An end marker
// closes the stream with a completion or error status that then sticks until reset. An
// accepted input word is loaded into the input register, and its state update is written
// into the result register, from which the result word is offered. Throughput is one word
// per cycle, set by the phase and length update loop; stalls on rsp_tready back up through
// the two registers without losing a word.
module name_value_pair_stream_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              req_tuser,   // [0] cmd
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nvp_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [7:0] out_byte, [38:8] name_len,
                                                          // [69:39] value_len,
                                                          // [85:70] pairs_done,
                                                          // [88:86] status, rest zero
   output logic [1:0]                        rsp_tuser,   // [1:0] byte_kind
   output logic                              rsp_tlast    // pair_done
);

   localparam int LEN_W   = nvp_pkg::LEN_W;
   localparam int LEFT_W  = nvp_pkg::LEFT_W;
   localparam int COUNT_W = nvp_pkg::COUNT_W;
   localparam int BYTE_W  = nvp_pkg::BYTE_W;
   localparam int PAD_W   = nvp_pkg::RSP_DATA_W - nvp_pkg::RSP_FIELDS_W;

   // Input register.
   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Parser state.
   nvp_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]          len_left_ff, len_left_in;
   logic [LEN_W-1:0]    name_len_ff, name_len_in;
   logic [LEN_W-1:0]    value_len_ff, value_len_in;
   logic [LEFT_W-1:0]   data_left_ff, data_left_in;
   logic [COUNT_W-1:0]  pair_total_ff, pair_total_in;
   nvp_pkg::status_type status_ff, status_in;

   // Result register.
   logic                            out_valid_ff;
   logic [nvp_pkg::RSP_DATA_W-1:0]  out_data_ff, out_data_in;
   logic [1:0]                      out_kind_ff;
   logic                            out_last_ff;

   // Combinational result fields.
   nvp_pkg::kind_type   kind;
   nvp_pkg::status_type word_status;
   logic                done;
   logic                show_len;
   logic [BYTE_W-1:0]   out_byte;

   // Helper values.
   logic              out_load;
   logic              step;
   logic [1:0]        left_eff;
   logic [LEN_W-1:0]  first_len;
   logic [LEN_W-1:0]  more_name_len;
   logic [LEN_W-1:0]  more_value_len;
   logic [LEFT_W-1:0] len_sum;
   logic              sum_zero;
   logic              data_last;
   logic              count_pair;

   // Handshake: result register loads when empty or draining; input register follows.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Length byte decoding shared by both lengths.
   assign left_eff  = (len_left_ff == 2'd0) ? 2'd1 : len_left_ff;
   assign first_len = in_byte_ff[7] ? {in_byte_ff[6:0], 24'd0}
                                    : {{(LEN_W-BYTE_W){1'b0}}, in_byte_ff};

   always_comb begin
      logic [LEN_W-1:0] shifted;
      shifted = {{(LEN_W-BYTE_W){1'b0}}, in_byte_ff};
      case (left_eff)
         2'd3:    shifted = shifted << 16;
         2'd2:    shifted = shifted << 8;
         default: shifted = shifted;
      endcase
      more_name_len  = name_len_ff | shifted;
      more_value_len = value_len_ff | shifted;
   end

   // Total data bytes of the pair once both lengths are known; the value length is the one
   // being completed by this word.
   assign len_sum   = {1'b0, name_len_ff}
                    + {1'b0, (phase_ff == nvp_pkg::PH_VALUE_LEN) ? first_len : more_value_len};
   assign sum_zero  = (len_sum == '0);
   assign data_last = (data_left_ff <= LEFT_W'(1));

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (in_cmd_ff == nvp_pkg::CMD_END) begin
         phase_in = nvp_pkg::PH_CLOSED;
      end else begin
         case (phase_ff)
            nvp_pkg::PH_NAME_LEN: begin
               phase_in = in_byte_ff[7] ? nvp_pkg::PH_NAME_LEN_MORE : nvp_pkg::PH_VALUE_LEN;
            end
            nvp_pkg::PH_NAME_LEN_MORE: begin
               if (left_eff == 2'd1) phase_in = nvp_pkg::PH_VALUE_LEN;
            end
            nvp_pkg::PH_VALUE_LEN: begin
               if (in_byte_ff[7]) phase_in = nvp_pkg::PH_VALUE_LEN_MORE;
               else phase_in = sum_zero ? nvp_pkg::PH_NAME_LEN : nvp_pkg::PH_DATA;
            end
            nvp_pkg::PH_VALUE_LEN_MORE: begin
               if (left_eff == 2'd1) begin
                  phase_in = sum_zero ? nvp_pkg::PH_NAME_LEN : nvp_pkg::PH_DATA;
               end
            end
            nvp_pkg::PH_DATA: begin
               if (data_last) phase_in = nvp_pkg::PH_NAME_LEN;
            end
            default: phase_in = nvp_pkg::PH_CLOSED;
         endcase
      end
   end

   // Datapath and result fields.
   always_comb begin
      len_left_in  = len_left_ff;
      name_len_in  = name_len_ff;
      value_len_in = value_len_ff;
      data_left_in = data_left_ff;
      status_in    = status_ff;
      kind         = nvp_pkg::KIND_LENGTH;
      out_byte     = in_byte_ff;
      done         = 1'b0;
      show_len     = 1'b1;
      word_status  = nvp_pkg::ST_OK;
      if (in_cmd_ff == nvp_pkg::CMD_END) begin
         kind     = nvp_pkg::KIND_END;
         out_byte = '0;
         show_len = 1'b0;
         case (phase_ff)
            nvp_pkg::PH_NAME_LEN:  status_in = nvp_pkg::ST_COMPLETE;
            nvp_pkg::PH_VALUE_LEN: status_in = nvp_pkg::ST_MISSING_VAL;
            nvp_pkg::PH_DATA:      status_in = nvp_pkg::ST_TRUNC_DATA;
            nvp_pkg::PH_CLOSED:    status_in = status_ff;
            default:               status_in = nvp_pkg::ST_TRUNC_LEN;
         endcase
         word_status = status_in;
      end else begin
         case (phase_ff)
            nvp_pkg::PH_NAME_LEN: begin
               value_len_in = '0;
               name_len_in  = first_len;
               len_left_in  = in_byte_ff[7] ? 2'd3 : 2'd0;
            end
            nvp_pkg::PH_NAME_LEN_MORE: begin
               name_len_in = more_name_len;
               len_left_in = left_eff - 2'd1;
            end
            nvp_pkg::PH_VALUE_LEN: begin
               value_len_in = first_len;
               len_left_in  = in_byte_ff[7] ? 2'd3 : 2'd0;
               if (!in_byte_ff[7]) begin
                  data_left_in = len_sum;
                  done         = sum_zero;
               end
            end
            nvp_pkg::PH_VALUE_LEN_MORE: begin
               value_len_in = more_value_len;
               len_left_in  = left_eff - 2'd1;
               if (left_eff == 2'd1) begin
                  data_left_in = len_sum;
                  done         = sum_zero;
               end
            end
            nvp_pkg::PH_DATA: begin
               kind = (data_left_ff > {1'b0, value_len_ff}) ? nvp_pkg::KIND_NAME
                                                            : nvp_pkg::KIND_VALUE;
               if (data_left_ff != '0) data_left_in = data_left_ff - LEFT_W'(1);
               done = data_last;
            end
            default: begin
               show_len    = 1'b0;
               word_status = status_ff;
            end
         endcase
      end
   end

   // Saturating pair counter.
   assign count_pair    = done && (pair_total_ff != nvp_pkg::COUNT_MAX);
   assign pair_total_in = count_pair ? pair_total_ff + COUNT_W'(1) : pair_total_ff;

   // Result word packing.
   assign out_data_in = {{PAD_W{1'b0}},
                         word_status,
                         pair_total_in,
                         show_len ? value_len_in : {LEN_W{1'b0}},
                         show_len ? name_len_in : {LEN_W{1'b0}},
                         out_byte};

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= nvp_pkg::PH_NAME_LEN;
         len_left_ff   <= '0;
         name_len_ff   <= '0;
         value_len_ff  <= '0;
         data_left_ff  <= '0;
         pair_total_ff <= '0;
         status_ff     <= nvp_pkg::ST_OK;
      end else if (step) begin
         phase_ff      <= phase_in;
         len_left_ff   <= len_left_in;
         name_len_ff   <= name_len_in;
         value_len_ff  <= value_len_in;
         data_left_ff  <= data_left_in;
         pair_total_ff <= pair_total_in;
         status_ff     <= status_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
      if (step) begin
         out_data_ff <= out_data_in;
         out_kind_ff <= kind;
         out_last_ff <= done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
